// File: rtl/conv3x3_replicate_border_top_assert.svh
// Assertion macros for the 3x3 convolution block
`ifndef CONV3X3_REPLICATE_BORDER_TOP_ASSERT_SVH
`define CONV3X3_REPLICATE_BORDER_TOP_ASSERT_SVH
// implication checked every clock, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// implication checked in the next cycle
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// File: rtl/c3rb_pkg.sv
// Shared types and constants for the 3x3 convolution block
package c3rb_pkg;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int PIXEL_BITS_DEF = 8;
   localparam int COEF_BITS_DEF  = 16;
   localparam int SUM_BITS       = 28;
   localparam int ROW_BITS       = 16;
   localparam int COL_BITS       = 10;
   localparam int WREG_BITS      = 11;
   localparam int KREG_BITS      = 48;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 48;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WIDTH  = 3'd0,
      CSR_HEIGHT = 3'd1,
      CSR_KTOP   = 3'd2,
      CSR_KMID   = 3'd3,
      CSR_KBOT   = 3'd4
   } csr_idx_type;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // control word from front to back
   typedef struct packed {
      logic            shift;   // window advances
      logic            emit_a;  // first result (column c-1)
      logic            emit_b;  // second result (column c)
      logic            left_rep; // replicate left edge for result a
      logic            done;
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
   } ctl_type;
endpackage

// File: rtl/c3rb_front.sv
// Front: counters, line buffers and window column fetch
module c3rb_front import c3rb_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [WREG_BITS-1:0]  cfg_width,
   input  logic [ROW_BITS-1:0]   cfg_height,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_op,
   input  logic [PIXEL_BITS-1:0] in_pix,
   output logic                  q_valid,
   input  logic                  q_ready,
   output ctl_type               q_ctl,
   output logic [3*PIXEL_BITS-1:0] q_col
);
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW = AW + 1;

   logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] newer_mem [MAX_WIDTH];

   logic [CW-1:0]       col_ff, col_in, drain_ff, drain_in;
   logic [ROW_BITS:0]   row_ff, row_in;
   logic                s1_valid_ff, s1_op_ff, s1_act_ff;
   logic [PIXEL_BITS-1:0] s1_pix_ff;
   logic [AW-1:0]       s1_addr_ff;
   ctl_type             s1_ctl_ff, ctl_in;
   logic [PIXEL_BITS-1:0] rd_old_ff, rd_new_ff;
   logic [CW-1:0]       w, c, d;
   logic [ROW_BITS:0]   h, r;
   logic                acc, act;
   logic [AW-1:0]       addr;
   logic                adv;

   always_comb begin
      w = (cfg_width < 11'd2) ? CW'(2) :
          (32'(cfg_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(cfg_width);
      h = (cfg_height < 16'd2) ? (ROW_BITS+1)'(2) : {1'b0, cfg_height};
      c = (col_ff >= w) ? w - 1'b1 : col_ff;
      d = (drain_ff >= w) ? w - 1'b1 : drain_ff;
      r = (row_ff > h) ? h : row_ff;
   end

   // stage 1 issues a memory read; advance when stage 1 empty or draining to queue
   assign adv      = !s1_valid_ff || q_ready;
   assign in_ready = adv;
   assign acc      = in_valid && in_ready;

   // act marks a used beat: a pixel stored in the line buffers or a drain beat
   always_comb begin
      col_in   = c;
      drain_in = d;
      row_in   = r;
      ctl_in   = '0;
      act      = 1'b0;
      addr     = AW'(c);
      if (in_op == OP_PIXEL) begin
         if (r < h) begin
            act          = 1'b1;
            ctl_in.shift = r >= 1;
            ctl_in.emit_a = ctl_in.shift && (c >= 1);
            ctl_in.emit_b = ctl_in.shift && (c == w - 1'b1);
            ctl_in.left_rep = c == CW'(1);
            ctl_in.row   = ROW_BITS'(r - 1'b1);
            ctl_in.col   = COL_BITS'(c);
            if (c == w - 1'b1) begin
               col_in = '0;
               row_in = r + 1'b1;
            end else begin
               col_in = c + 1'b1;
            end
         end
      end else begin
         addr = AW'(d);
         if (r >= h) begin
            act          = 1'b1;
            ctl_in.shift = 1'b1;
            ctl_in.emit_a = d >= 1;
            ctl_in.emit_b = d == w - 1'b1;
            ctl_in.done  = d == w - 1'b1;
            ctl_in.left_rep = d == CW'(1);
            ctl_in.row   = ROW_BITS'(h - 1'b1);
            ctl_in.col   = COL_BITS'(d);
            if (d == w - 1'b1) begin
               row_in = '0; col_in = '0; drain_in = '0;
            end else begin
               drain_in = d + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0; drain_ff <= '0; row_ff <= '0; s1_valid_ff <= 1'b0;
      end else if (acc) begin
         col_ff <= col_in; drain_ff <= drain_in; row_ff <= row_in;
         s1_valid_ff <= 1'b1;
      end else if (adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_op_ff <= in_op; s1_pix_ff <= in_pix; s1_addr_ff <= addr;
         s1_ctl_ff <= ctl_in; s1_act_ff <= act;
         rd_old_ff <= older_mem[addr];
         rd_new_ff <= newer_mem[addr];
      end
   end

   // write back in stage 1; a same-address read in the next beat would see stale data,
   // but consecutive act beats always use different columns (width at least two)
   always_ff @(posedge clock) begin
      if (s1_valid_ff && adv && s1_op_ff == OP_PIXEL && s1_ctl_ff.shift)
         older_mem[s1_addr_ff] <= rd_new_ff;
   end
   always_ff @(posedge clock) begin
      if (s1_valid_ff && adv && s1_op_ff == OP_PIXEL && s1_act_ff)
         newer_mem[s1_addr_ff] <= s1_pix_ff;
   end

   logic [PIXEL_BITS-1:0] top, mid, bot;
   always_comb begin
      mid = rd_new_ff;
      if (s1_op_ff == OP_PIXEL) begin
         bot = s1_pix_ff;
         top = (s1_ctl_ff.row == '0) ? rd_new_ff : rd_old_ff;
      end else begin
         bot = rd_new_ff;
         top = rd_old_ff;
      end
   end
   assign q_valid = s1_valid_ff && s1_ctl_ff.shift;
   assign q_ctl   = s1_ctl_ff;
   assign q_col   = {bot, mid, top};
endmodule

// File: rtl/c3rb_queue.sv
// Short queue between front and back
module c3rb_queue import c3rb_pkg::*; #(
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_valid,
   output logic          wr_ready,
   input  logic [DW-1:0] wr_data,
   output logic          rd_valid,
   input  logic          rd_ready,
   output logic [DW-1:0] rd_data
);
   logic [DW-1:0] slot_ff [2];
   logic          wp_ff, rp_ff;
   logic [1:0]    cnt_ff;
   logic          wr, rd;
   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;
   assign rd_data = slot_ff[rp_ff];
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
   end
   always_ff @(posedge clock) begin
      if (wr) slot_ff[wp_ff] <= wr_data;
   end
endmodule

// File: rtl/c3rb_back.sv
// Back: window shift, nine products, sum tree and result sequencing
module c3rb_back import c3rb_pkg::*; #(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF,
   parameter int COEF_BITS  = COEF_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [KREG_BITS-1:0]    kern [3],
   input  logic                    q_valid,
   output logic                    q_ready,
   input  ctl_type                 q_ctl,
   input  logic [3*PIXEL_BITS-1:0] q_col,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [SUM_BITS-1:0] rsp_filtered_value,
   output logic [ROW_BITS-1:0]     rsp_out_row,
   output logic [COL_BITS-1:0]     rsp_out_column,
   output logic                    rsp_last_of_run,
   output logic                    rsp_frame_done
);
   localparam int PW = PIXEL_BITS + COEF_BITS + 1;

   logic [PIXEL_BITS-1:0] win_ff [3][3];   // [col][row]
   logic                  v1_ff, sel_ff;
   ctl_type               c1_ff;
   logic signed [PW-1:0]  prod_ff [3][3]; // [kcol][row]
   logic                  v2_ff, last2_ff, done2_ff;
   logic [ROW_BITS-1:0]   row2_ff;
   logic [COL_BITS-1:0]   col2_ff;
   logic signed [SUM_BITS-1:0] rsp_val_ff;
   logic [ROW_BITS-1:0]   rsp_row_ff;
   logic [COL_BITS-1:0]   rsp_col_ff;
   logic                  rsp_v_ff, rsp_last_ff, rsp_done_ff;
   logic [PIXEL_BITS-1:0] wsel [3][3];
   logic                  adv1, adv2, out_free, emit1, pair, use_b;
   logic signed [SUM_BITS-1:0] sum;

   function automatic logic signed [COEF_BITS:0] coef(input logic [KREG_BITS-1:0] k,
                                                     input int idx);
      logic [COEF_BITS-1:0] v;
      v = k[16*idx +: COEF_BITS];
      return {v[COEF_BITS-1], v};
   endfunction

   assign out_free = !rsp_v_ff || rsp_ready;
   assign adv2     = !v2_ff || out_free;
   assign emit1    = v1_ff && (c1_ff.emit_a || c1_ff.emit_b);
   assign pair     = c1_ff.emit_a && c1_ff.emit_b;
   assign use_b    = sel_ff || !c1_ff.emit_a;
   // a two-result beat holds the window stage until both are issued
   assign adv1     = !emit1 || (adv2 && (!pair || sel_ff));
   assign q_ready  = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) win_ff[i][j] <= '0;
         v1_ff <= 1'b0;
      end else if (adv1) begin
         v1_ff <= q_valid;
         if (q_valid) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[0][j] <= win_ff[1][j];
               win_ff[1][j] <= win_ff[2][j];
               win_ff[2][j] <= q_col[j*PIXEL_BITS +: PIXEL_BITS];
            end
         end
      end
   end
   always_ff @(posedge clock) begin
      if (adv1 && q_valid) c1_ff <= q_ctl;
   end

   always_ff @(posedge clock) begin
      if (reset) sel_ff <= 1'b0;
      else if (emit1 && pair && adv2) sel_ff <= !sel_ff;
   end

   // result a uses columns (left, 1, 2), result b uses (1, 2, 2)
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         if (use_b) begin
            wsel[0][j] = win_ff[1][j]; wsel[1][j] = win_ff[2][j];
            wsel[2][j] = win_ff[2][j];
         end else begin
            wsel[0][j] = c1_ff.left_rep ? win_ff[1][j] : win_ff[0][j];
            wsel[1][j] = win_ff[1][j]; wsel[2][j] = win_ff[2][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv2) v2_ff <= emit1;
   end

   always_ff @(posedge clock) begin
      if (adv2 && emit1) begin
         row2_ff  <= c1_ff.row;
         col2_ff  <= use_b ? c1_ff.col : c1_ff.col - 1'b1;
         last2_ff <= use_b || !c1_ff.emit_b;
         done2_ff <= use_b && c1_ff.done;
         for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++)
               prod_ff[k][j] <= $signed(PW'({1'b0, wsel[k][j]})) * PW'(coef(kern[j], k));
      end
   end

   always_comb begin
      sum = '0;
      for (int k = 0; k < 3; k++)
         for (int j = 0; j < 3; j++) sum = sum + SUM_BITS'(prod_ff[k][j]);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_v_ff <= 1'b0;
      else if (out_free) rsp_v_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (out_free && v2_ff) begin
         rsp_val_ff  <= sum;
         rsp_row_ff  <= row2_ff;
         rsp_col_ff  <= col2_ff;
         rsp_last_ff <= last2_ff;
         rsp_done_ff <= done2_ff;
      end
   end
   assign rsp_valid          = rsp_v_ff;
   assign rsp_filtered_value = rsp_val_ff;
   assign rsp_out_row        = rsp_row_ff;
   assign rsp_out_column     = rsp_col_ff;
   assign rsp_last_of_run    = rsp_last_ff;
   assign rsp_frame_done     = rsp_done_ff;
endmodule

// File: rtl/conv3x3_replicate_border_top.sv
// 3x3 replicate-border convolution: top level
// Usage:
//  Configure width, height and three kernel rows through csr_ (index 0..4)
//  while idle. Stream pixels in row order on req_ with req_opcode 0; after
//  the last pixel send width drain beats (req_opcode 1) to flush the last row.
//  Results leave on rsp_: one per beat from the second column on (none for
//  first-row pixels), two at the end of a row, the last of a beat's results
//  flagged by rsp_last_of_run and the bottom right pixel by rsp_frame_done.
//  The first result of a req_ beat passes a line buffer read stage, a
//  two-entry queue, the window stage and the product stage, then the
//  output register.
//  Throughput is one beat per cycle while rsp_ready stays high; a beat with
//  two results holds the window stage until the second follows the first.
//  Reset clears counters and window; line buffers hold unknown data until
//  written, and need no clearing pass.
//  When rsp_ready is low the output register holds, the queue fills, and
//  req_ready drops once the queue is full.
`include "conv3x3_replicate_border_top_assert.svh"
module conv3x3_replicate_border_top import c3rb_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = PIXEL_BITS_DEF,
   parameter int COEF_BITS  = COEF_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_opcode,
   input  logic [PIXEL_BITS-1:0]    req_pixel_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [SUM_BITS-1:0] rsp_filtered_value,
   output logic [ROW_BITS-1:0]      rsp_out_row,
   output logic [COL_BITS-1:0]      rsp_out_column,
   output logic                     rsp_last_of_run,
   output logic                     rsp_frame_done
);
   localparam int QW = $bits(ctl_type) + 3*PIXEL_BITS;
   logic [WREG_BITS-1:0] width_ff;
   logic [ROW_BITS-1:0]  height_ff;
   logic [KREG_BITS-1:0] kern_ff [3];
   logic                 fq_valid, fq_ready, bq_valid, bq_ready;
   ctl_type              f_ctl, b_ctl;
   logic [3*PIXEL_BITS-1:0] f_col, b_col;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WREG_BITS'(1024); height_ff <= ROW_BITS'(2);
         for (int i = 0; i < 3; i++) kern_ff[i] <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff <= csr_data[WREG_BITS-1:0];
            CSR_HEIGHT: height_ff <= csr_data[ROW_BITS-1:0];
            CSR_KTOP:   kern_ff[0] <= csr_data;
            CSR_KMID:   kern_ff[1] <= csr_data;
            CSR_KBOT:   kern_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   c3rb_front #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_front (
      .clock, .reset, .cfg_width(width_ff), .cfg_height(height_ff),
      .in_valid(req_valid), .in_ready(req_ready), .in_op(req_opcode),
      .in_pix(req_pixel_value), .q_valid(fq_valid), .q_ready(fq_ready),
      .q_ctl(f_ctl), .q_col(f_col));

   c3rb_queue #(.DW(QW)) u_queue (
      .clock, .reset, .wr_valid(fq_valid), .wr_ready(fq_ready),
      .wr_data({f_ctl, f_col}), .rd_valid(bq_valid), .rd_ready(bq_ready),
      .rd_data({b_ctl, b_col}));

   c3rb_back #(.PIXEL_BITS(PIXEL_BITS), .COEF_BITS(COEF_BITS)) u_back (
      .clock, .reset, .kern(kern_ff), .q_valid(bq_valid), .q_ready(bq_ready),
      .q_ctl(b_ctl), .q_col(b_col), .rsp_valid, .rsp_ready, .rsp_filtered_value,
      .rsp_out_row, .rsp_out_column, .rsp_last_of_run, .rsp_frame_done);

   `ASSERT_IMPLIES(a_done_last, clock, reset, rsp_valid && rsp_frame_done, rsp_last_of_run)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_IMPLIES(a_col_range, clock, reset, rsp_valid, 32'(rsp_out_column) < MAX_WIDTH)
endmodule

// File: verif/conv3x3_filter_checker.sv
// Checker for the 3x3 replicate-border convolution: predicts and compares results
`timescale 1ns / 100ps
module conv3x3_filter_checker import c3rb_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [CSR_IDX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_data,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_opcode,
   input  logic [PIXEL_BITS_DEF-1:0]   req_pixel_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic signed [SUM_BITS-1:0]  rsp_filtered_value,
   input  logic [ROW_BITS-1:0]         rsp_out_row,
   input  logic [COL_BITS-1:0]         rsp_out_column,
   input  logic                        rsp_last_of_run,
   input  logic                        rsp_frame_done,
   output int                          fail_count,
   output int                          pending
);
   typedef struct {
      logic [SUM_BITS-1:0] sum;
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
      logic                last;
      logic                done;
   } filtered_pixel_type;

   filtered_pixel_type expected_pixels[$];

   logic [WREG_BITS-1:0]      width_reg;
   logic [ROW_BITS-1:0]       height_reg;
   logic [KREG_BITS-1:0]      kernel_reg[3];
   logic [PIXEL_BITS_DEF-1:0] older_line[MAX_WIDTH_DEF];
   logic [PIXEL_BITS_DEF-1:0] newer_line[MAX_WIDTH_DEF];
   // window[col][row]: col 0 oldest, row 0 top
   logic [PIXEL_BITS_DEF-1:0] window[3][3];
   int unsigned               row_cnt, col_cnt, drain_col;
   int                        beat_results;

   assign pending = expected_pixels.size();

   task automatic shift_window(input logic [7:0] top, mid, bot);
      window[0] = window[1];
      window[1] = window[2];
      window[2][0] = top;
      window[2][1] = mid;
      window[2][2] = bot;
   endtask

   task automatic push_result(input int l, m, r, input int unsigned row, col,
                              input logic done);
      int                 cols[3];
      longint             acc;
      filtered_pixel_type e;
      cols = '{l, m, r};
      acc = 0;
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++)
            acc += longint'(window[cols[k]][i])
                   * longint'($signed(kernel_reg[i][16*k +: 16]));
      e.sum  = acc[SUM_BITS-1:0];
      e.row  = row[ROW_BITS-1:0];
      e.col  = col[COL_BITS-1:0];
      e.last = 1'b0;
      e.done = done;
      expected_pixels.push_back(e);
      beat_results++;
   endtask

   task automatic filter_beat(input logic op, input logic [7:0] pix);
      int unsigned w, h, c, r, d;
      logic [7:0]  mid, top;
      w = (width_reg < 2) ? 2 : (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
      h = (height_reg < 2) ? 2 : height_reg;
      beat_results = 0;
      if (col_cnt >= w) col_cnt = w - 1;
      if (drain_col >= w) drain_col = w - 1;
      if (row_cnt > h) row_cnt = h;
      if (op == OP_PIXEL) begin
         c = col_cnt;
         r = row_cnt;
         if (r >= h) return;
         if (r >= 1) begin
            mid = newer_line[c];
            top = (r >= 2) ? older_line[c] : mid;
            shift_window(top, mid, pix);
            if (c >= 1) push_result((c == 1) ? 1 : 0, 1, 2, r - 1, c - 1, 1'b0);
            if (c == w - 1) push_result(1, 2, 2, r - 1, c, 1'b0);
            older_line[c] = mid;
         end
         newer_line[c] = pix;
         if (c == w - 1) begin
            col_cnt = 0;
            row_cnt = r + 1;
         end else begin
            col_cnt = c + 1;
         end
      end else begin
         d = drain_col;
         if (row_cnt < h) return;
         // bottom border: replicate the last row
         shift_window(older_line[d], newer_line[d], newer_line[d]);
         if (d >= 1) push_result((d == 1) ? 1 : 0, 1, 2, h - 1, d - 1, 1'b0);
         if (d == w - 1) begin
            push_result(1, 2, 2, h - 1, d, 1'b1);
            row_cnt = 0;
            col_cnt = 0;
            drain_col = 0;
         end else begin
            drain_col = d + 1;
         end
      end
      if (beat_results > 0) expected_pixels[expected_pixels.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      filtered_pixel_type e;
      if (reset) begin
         width_reg  = 11'd1024;
         height_reg = 16'd2;
         for (int i = 0; i < 3; i++) kernel_reg[i] = '0;
         for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) window[i][k] = '0;
         row_cnt = 0;
         col_cnt = 0;
         drain_col = 0;
         fail_count = 0;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_WIDTH:  width_reg = csr_data[WREG_BITS-1:0];
               CSR_HEIGHT: height_reg = csr_data[ROW_BITS-1:0];
               CSR_KTOP:   kernel_reg[0] = csr_data[KREG_BITS-1:0];
               CSR_KMID:   kernel_reg[1] = csr_data[KREG_BITS-1:0];
               CSR_KBOT:   kernel_reg[2] = csr_data[KREG_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) filter_beat(req_opcode, req_pixel_value);
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result beat: value %0d row %0d col %0d",
                           rsp_filtered_value, rsp_out_row, rsp_out_column);
            end else begin
               e = expected_pixels.pop_front();
               if (rsp_filtered_value !== e.sum || rsp_out_row !== e.row ||
                   rsp_out_column !== e.col || rsp_last_of_run !== e.last ||
                   rsp_frame_done !== e.done) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %0d r%0d c%0d l%0b d%0b, got %0d r%0d c%0d l%0b d%0b",
                              $signed(e.sum), e.row, e.col, e.last, e.done,
                              rsp_filtered_value, rsp_out_row, rsp_out_column,
                              rsp_last_of_run, rsp_frame_done);
               end
            end
         end
      end
   end
endmodule

// File: verif/conv3x3_replicate_border_top_tb.sv
// Testbench top for the 3x3 replicate-border convolution: stimulus and verdict
`timescale 1ns / 100ps
module conv3x3_replicate_border_top_tb;
   import c3rb_pkg::*;

   logic                        clock;
   logic                        reset;
   logic                        csr_valid, csr_ready;
   logic [CSR_IDX_BITS-1:0]     csr_index;
   logic [CSR_DATA_BITS-1:0]    csr_data;
   logic                        req_valid, req_ready;
   logic                        req_opcode;
   logic [PIXEL_BITS_DEF-1:0]   req_pixel_value;
   logic                        rsp_valid, rsp_ready;
   logic signed [SUM_BITS-1:0]  rsp_filtered_value;
   logic [ROW_BITS-1:0]         rsp_out_row;
   logic [COL_BITS-1:0]         rsp_out_column;
   logic                        rsp_last_of_run, rsp_frame_done;
   int                          fail_count, pending;
   int                          sender_idle, receiver_idle;
   int                          beats_sent;

   conv3x3_replicate_border_top u_dut (.*);

   conv3x3_filter_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("conv3x3_replicate_border_top_tb NOT OK");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off to back the block up
   initial begin
      bit held;
      held = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && beats_sent >= 60) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= receiver_idle);
      end
   end

   task automatic send_beat(input logic op, input logic [7:0] pix);
      while ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_pixel_value <= pix;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (12) @(negedge clock);
   endtask

   function automatic logic [KREG_BITS-1:0] pick_kernel_row();
      case ($urandom_range(5))
         0: return {3{16'h8000}};
         1: return {3{16'h7FFF}};
         2: return {16'h8000, 16'h7FFF, 16'hFFFF};
         default: return KREG_BITS'({$urandom(), $urandom()});
      endcase
   endfunction

   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom());
      endcase
   endfunction

   // one image: w*h pixels then w drain beats, with optional stray beats
   task automatic stream_image(input int w, h, input bit noisy);
      for (int i = 0; i < w * h; i++) begin
         if (noisy && $urandom_range(99) < 3) send_beat(OP_DRAIN, pick_pixel());
         send_beat(OP_PIXEL, pick_pixel());
      end
      if (noisy && $urandom_range(99) < 30) send_beat(OP_PIXEL, pick_pixel());
      for (int i = 0; i < w; i++) send_beat(OP_DRAIN, pick_pixel());
   endtask

   task automatic random_image(input int wreg);
      int w, hreg, h;
      hreg = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 6);
      w = (wreg < 2) ? 2 : (wreg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : wreg;
      h = (hreg < 2) ? 2 : hreg;
      write_reg(CSR_WIDTH, CSR_DATA_BITS'(wreg));
      write_reg(CSR_HEIGHT, CSR_DATA_BITS'(hreg));
      write_reg(CSR_KTOP, pick_kernel_row());
      write_reg(CSR_KMID, pick_kernel_row());
      write_reg(CSR_KBOT, pick_kernel_row());
      stream_image(w, h, ($urandom_range(3) != 0));
      wait_idle();
   endtask

   initial begin
      int wreg, target;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = CSR_WIDTH;
      csr_data = '0;
      req_valid = 1'b0;
      req_opcode = OP_PIXEL;
      req_pixel_value = '0;
      beats_sent = 0;
      sender_idle = 0;
      receiver_idle = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: 3x3 image with extreme kernel, stray drain and stray pixel
      write_reg(CSR_WIDTH, CSR_DATA_BITS'(3));
      write_reg(CSR_HEIGHT, CSR_DATA_BITS'(3));
      write_reg(CSR_KTOP, {16'h8000, 16'h7FFF, 16'h8000});
      write_reg(CSR_KMID, {16'h7FFF, 16'h8000, 16'h7FFF});
      write_reg(CSR_KBOT, {16'hFFFF, 16'h0001, 16'h8000});
      send_beat(OP_DRAIN, 8'd0);
      for (int i = 0; i < 9; i++) send_beat(OP_PIXEL, (i % 2) ? 8'd0 : 8'd255);
      send_beat(OP_PIXEL, 8'd255);
      for (int i = 0; i < 3; i++) send_beat(OP_DRAIN, 8'd255);
      wait_idle();
      // width and height below range clamp to 2
      write_reg(CSR_WIDTH, CSR_DATA_BITS'(1));
      write_reg(CSR_HEIGHT, CSR_DATA_BITS'(0));
      for (int i = 0; i < 4; i++) send_beat(OP_PIXEL, 8'(i * 85));
      for (int i = 0; i < 2; i++) send_beat(OP_DRAIN, 8'd0);
      wait_idle();

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle   = (phase == 0) ? 38 : (phase == 1) ? 63 : 0;
         receiver_idle = (phase == 0) ? 63 : (phase == 1) ? 38 : 0;
         target = beats_sent + 580;
         while (beats_sent < target) begin
            case ($urandom_range(19))
               0: wreg = 0;
               1: wreg = 1;
               default: wreg = $urandom_range(2, 12);
            endcase
            random_image(wreg);
         end
      end

      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("conv3x3_replicate_border_top_tb OK");
      else
         $display("conv3x3_replicate_border_top_tb NOT OK");
      $finish;
   end
endmodule
